// ===== sv/srpc_pkg.sv =====
// ----------------------------------------------------------------------------
// srpc_pkg: shared types and constants for the slot run packet capacity block
// Widths, register indexes, reset values and divider handshake structs.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int MAP_SLOTS = 256;
  localparam int TIME_W    = 20;
  localparam int CNT_W     = 16;
  localparam int RUN_W     = $clog2(MAP_SLOTS + 1);
  localparam int SPAN_W    = $clog2(MAP_SLOTS) + TIME_W;
  localparam int STEP_W    = $clog2(SPAN_W);
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_SLOT_TIME  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GUARD_TIME = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_TIME = 2'd2;
  localparam logic [IDX_W-1:0] REG_TARGET     = 2'd3;

  localparam logic [TIME_W-1:0] SLOT_TIME_RST  = 20'd256000;
  localparam logic [TIME_W-1:0] GUARD_TIME_RST = 20'd12000;
  localparam logic [TIME_W-1:0] FRAME_TIME_RST = 20'd40000;
  localparam logic [CNT_W-1:0]  TARGET_RST     = 16'd0;

  localparam logic [CNT_W-1:0]  TOTAL_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic              start;
    logic [SPAN_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SPAN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/slot_run_packet_capacity_top.sv =====
// ----------------------------------------------------------------------------
// slot_run_packet_capacity_top: packet capacity of a reservation bitmap
// Counts reserved-slot runs, converts each closed run to packets with a
// serial divider and reports the total and shortfall on the last slot.
//
//   channel | dir | handshake               | payload
//   in      | in  | in_valid_i / in_stall_o | slot_reserved_i, last_slot_i
//   out     | out | out_valid_o/out_stall_i | possible_packets_o, missing_packets_o
//   cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A beat that closes no run leaves the block idle; the block takes the next beat at once.
// A beat that closes a run stalls the input through multiply, guard subtract,
// SPAN_W quotient bits and a done step in the divider, and skips the divider
// if the guard eats the run. A last-slot beat adds a finish step to load the
// result register, and waits there while a previous result is still stalled.
// Reset clears run length, total and all handshake state.
// ----------------------------------------------------------------------------
module slot_run_packet_capacity_top
  import srpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              slot_reserved_i,
  input  logic              last_slot_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CNT_W-1:0]  possible_packets_o,
  output logic [CNT_W-1:0]  missing_packets_o,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [TIME_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [TIME_W-1:0] slot_time_q;
  logic [TIME_W-1:0] guard_time_q;
  logic [TIME_W-1:0] frame_time_q;
  logic [CNT_W-1:0]  target_q;
  logic [RUN_W-1:0]  run_q;
  logic [RUN_W-1:0]  run_d;
  logic [CNT_W-1:0]  total_q;
  logic [SPAN_W-1:0] span_q;
  logic              last_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  possible_q;
  logic [CNT_W-1:0]  missing_q;
  logic              in_accept;
  logic              out_free;
  logic              result_load;
  logic [SPAN_W-1:0] product;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  total_add;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign result_load = (state_q == ST_FINISH) && out_free;
  // run <= MAP_SLOTS keeps the product inside SPAN_W bits
  assign product     = {{(SPAN_W-RUN_W){1'b0}}, run_q} *
                       {{(SPAN_W-TIME_W){1'b0}}, slot_time_q};

  always_comb begin
    run_d = run_q;
    if (slot_reserved_i && (run_q < RUN_W'(MAP_SLOTS))) begin
      run_d = run_q + RUN_W'(1);
    end
  end

  always_comb begin
    sum = {1'b0, total_q} + {1'b0, div_rsp.quotient[CNT_W-1:0]};
    if ((|div_rsp.quotient[SPAN_W-1:CNT_W]) || sum[CNT_W]) begin
      total_add = TOTAL_MAX;
    end else begin
      total_add = sum[CNT_W-1:0];
    end
  end

  always_comb begin
    div_req.start    = (state_q == ST_SUB) && (span_q > SPAN_W'(guard_time_q));
    div_req.dividend = span_q - SPAN_W'(guard_time_q);
    div_req.divisor  = frame_time_q;
  end

  srpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_time_q  <= SLOT_TIME_RST;
      guard_time_q <= GUARD_TIME_RST;
      frame_time_q <= FRAME_TIME_RST;
      target_q     <= TARGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOT_TIME:  slot_time_q  <= cfg_wdata_i;
        REG_GUARD_TIME: guard_time_q <= cfg_wdata_i;
        REG_FRAME_TIME: frame_time_q <= cfg_wdata_i;
        REG_TARGET:     target_q     <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      total_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            run_q  <= run_d;
            last_q <= last_slot_i;
            if ((!slot_reserved_i || last_slot_i) && (run_d != '0)) begin
              state_q <= ST_MUL;
            end else if (last_slot_i) begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_MUL: begin
          run_q   <= '0;
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          if (div_req.start) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= last_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            total_q <= total_add;
            state_q <= last_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            total_q <= '0;
            run_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      span_q <= product;
    end
    if (result_load) begin
      possible_q <= total_q;
      missing_q  <= (target_q > total_q) ? (target_q - total_q) : '0;
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign possible_packets_o = possible_q;
  assign missing_packets_o  = missing_q;

endmodule

// ===== sv/srpc_div.sv =====
// ----------------------------------------------------------------------------
// srpc_div: serial restoring divider
// One quotient bit per cycle; done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module srpc_div
  import srpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SPAN_W-1:0] num_q, num_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [TIME_W:0]   shifted;
  logic [TIME_W-1:0] diff;
  logic              ge;

  assign shifted = {rem_q, num_q[SPAN_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted[TIME_W-1:0] - dvs_q;

  always_comb begin
    num_d = {num_q[SPAN_W-2:0], ge};
    rem_d = ge ? diff : shifted[TIME_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SPAN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule

// ===== sv/srpc_chk.sv =====
// ----------------------------------------------------------------------------
// srpc_chk: port-level checks for slot_run_packet_capacity_top
// Watches the handshakes and the run/result sequencing from the ports.
// ----------------------------------------------------------------------------
module srpc_chk
  import srpc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              slot_reserved_i,
  input logic              last_slot_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CNT_W-1:0]  possible_packets_o,
  input logic [CNT_W-1:0]  missing_packets_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(possible_packets_o) && $stable(missing_packets_o))
    else $error("stalled result beat changed");

  a_run_extend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && slot_reserved_i && !last_slot_i |=> !in_stall_o)
    else $error("extending a run must not stall input");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a last-slot sequence");

endmodule

bind slot_run_packet_capacity_top srpc_chk u_srpc_chk (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for slot_run_packet_capacity_top
// Feeds reservation maps slot by slot with random gaps and output stalls.
// A local capacity model predicts each per-map packet count and shortfall;
// results are checked in order. A scripted part covers reset values,
// register extremes, zero frame time, oversized guards and mid-map register
// writes. Random maps with random register settings, long runs past the map
// size and one long output hold-off follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import srpc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] possible;
    logic [CNT_W-1:0] missing;
  } cap_t;

  typedef enum logic {ROW_SLOT, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              reserved;
    logic              last;
    logic              typed;
    cap_t              cap;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] data;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              slot_reserved = 1'b0;
  logic              last_slot = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CNT_W-1:0]  possible_packets;
  logic [CNT_W-1:0]  missing_packets;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_idx = REG_SLOT_TIME;
  logic [TIME_W-1:0] cfg_wdata = '0;

  // capacity model
  logic [TIME_W-1:0] slot_ns;
  logic [TIME_W-1:0] guard_ns;
  logic [TIME_W-1:0] frame_ns;
  logic [CNT_W-1:0]  target_pk;
  logic [RUN_W-1:0]  run_cnt;
  logic [CNT_W-1:0]  pk_total;

  cap_t caps_due[$];
  row_t script[$];
  int   fails = 0;
  int   beats_sent = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;

  slot_run_packet_capacity_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .slot_reserved_i    (slot_reserved),
    .last_slot_i        (last_slot),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .possible_packets_o (possible_packets),
    .missing_packets_o  (missing_packets),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic close_run();
    logic [63:0] span;
    logic [63:0] quot;
    logic [63:0] sum;
    if (run_cnt == '0) return;
    span = {55'd0, run_cnt};
    span = span * {44'd0, slot_ns};
    if (span > {44'd0, guard_ns}) begin
      span = span - {44'd0, guard_ns};
      if (frame_ns == '0) quot = {48'd0, TOTAL_MAX};
      else quot = span / {44'd0, frame_ns};
      sum = {48'd0, pk_total} + quot;
      pk_total = (sum > {48'd0, TOTAL_MAX}) ? TOTAL_MAX : sum[CNT_W-1:0];
    end
    run_cnt = '0;
  endtask

  task automatic account_slot(input logic reserved, input logic last,
                              output bit got, output cap_t cap);
    got = 1'b0;
    cap = '0;
    if (reserved) begin
      if (run_cnt < MAP_SLOTS) run_cnt = run_cnt + RUN_W'(1);
    end else begin
      close_run();
    end
    if (last) begin
      close_run();
      cap.possible = pk_total;
      cap.missing  = (target_pk > pk_total) ? target_pk - pk_total : '0;
      run_cnt  = '0;
      pk_total = '0;
      got = 1'b1;
    end
  endtask

  task automatic send(input logic reserved, input logic last,
                      input logic typed, input cap_t typed_cap);
    int   gap;
    bit   got;
    cap_t cap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    slot_reserved <= reserved;
    last_slot     <= last;
    do @(posedge clk); while (in_stall);
    account_slot(reserved, last, got, cap);
    if (got) caps_due = {caps_due, (typed ? typed_cap : cap)};
    beats_sent++;
  endtask

  // block idle: no beat offered, all results in, divider done
  task automatic quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (caps_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_SLOT_TIME:  slot_ns   = data;
      REG_GUARD_TIME: guard_ns  = data;
      REG_FRAME_TIME: frame_ns  = data;
      REG_TARGET:     target_pk = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic add_row(input row_t row);
    script = {script, row};
  endtask

  function automatic row_t slot_row(input logic r, input logic l);
    row_t row;
    row = '0;
    row.kind = ROW_SLOT;
    row.reserved = r;
    row.last = l;
    return row;
  endfunction

  function automatic row_t check_row(input logic r, input logic l,
                                     input logic [CNT_W-1:0] pp,
                                     input logic [CNT_W-1:0] mp);
    row_t row;
    row = slot_row(r, l);
    row.typed = 1'b1;
    row.cap.possible = pp;
    row.cap.missing = mp;
    return row;
  endfunction

  function automatic row_t reg_row(input logic [IDX_W-1:0] idx,
                                   input logic [TIME_W-1:0] data);
    row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time(input int lo);
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return TIME_W'(lo);
      2:       return TIME_W'($urandom_range(1, 16));
      3, 4:    return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1000, 300000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {4'd0, TOTAL_MAX};
      2:       return {4'd0, 16'($urandom)};
      default: return TIME_W'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic send_map(input int len, input int density);
    logic r;
    logic l;
    for (int i = 0; i < len; i++) begin
      r = ($urandom_range(0, 99) < density);
      l = (i == len - 1);
      if ($urandom_range(0, 19) == 0) begin
        r = 1'($urandom);
        l = 1'($urandom);
      end
      send(r, l, 1'b0, '0);
    end
  endtask

  // receiver: per result stall draw, one long hold-off on request
  initial begin
    int   n;
    cap_t want;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = 400;
      end else begin
        n = calm ? 0 : $urandom_range(0, 6);
      end
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (caps_due.size() == 0) begin
        $error("unexpected beat: possible_packets %0d, missing_packets %0d",
               possible_packets, missing_packets);
        fails++;
      end else begin
        want = caps_due.pop_front();
        if (possible_packets !== want.possible) begin
          $error("possible_packets: expected %0d, actual %0d", want.possible,
                 possible_packets);
          fails++;
        end
        if (missing_packets !== want.missing) begin
          $error("missing_packets: expected %0d, actual %0d", want.missing,
                 missing_packets);
          fails++;
        end
      end
    end
  end

  initial begin
    int   len;
    int   density;
    int   phase;
    bit   dirty;
    row_t row;

    slot_ns   = SLOT_TIME_RST;
    guard_ns  = GUARD_TIME_RST;
    frame_ns  = FRAME_TIME_RST;
    target_pk = TARGET_RST;
    run_cnt   = '0;
    pk_total  = '0;

    add_row(check_row(1'b0, 1'b1, 16'd0, 16'd0));
    add_row(check_row(1'b1, 1'b1, 16'd6, 16'd0));   // (256000-12000)/40000
    add_row(slot_row(1'b1, 1'b0));
    add_row(slot_row(1'b1, 1'b0));
    add_row(slot_row(1'b0, 1'b0));
    add_row(slot_row(1'b1, 1'b1));
    add_row(reg_row(REG_TARGET, 20'd65535));
    add_row(check_row(1'b0, 1'b1, 16'd0, 16'd65535));
    // guard longer than any run
    add_row(reg_row(REG_SLOT_TIME, 20'd1));
    add_row(reg_row(REG_GUARD_TIME, 20'hFFFFF));
    add_row(slot_row(1'b1, 1'b0));
    add_row(check_row(1'b1, 1'b1, 16'd0, 16'd65535));
    // zero frame time
    add_row(reg_row(REG_FRAME_TIME, 20'd0));
    add_row(reg_row(REG_GUARD_TIME, 20'd0));
    add_row(reg_row(REG_SLOT_TIME, 20'hFFFFF));
    add_row(check_row(1'b1, 1'b1, 16'd65535, 16'd0));
    add_row(slot_row(1'b0, 1'b0));
    add_row(check_row(1'b0, 1'b1, 16'd0, 16'd65535));
    add_row(reg_row(REG_FRAME_TIME, 20'd1));
    add_row(slot_row(1'b1, 1'b0));
    add_row(check_row(1'b1, 1'b1, 16'd65535, 16'd0));
    add_row(reg_row(REG_SLOT_TIME, 20'd0));
    add_row(check_row(1'b1, 1'b1, 16'd0, 16'd65535));
    // register write inside a map
    add_row(reg_row(REG_SLOT_TIME, 20'd256000));
    add_row(reg_row(REG_GUARD_TIME, 20'd12000));
    add_row(reg_row(REG_FRAME_TIME, 20'd40000));
    add_row(reg_row(REG_TARGET, 20'd100));
    add_row(slot_row(1'b1, 1'b0));
    add_row(slot_row(1'b1, 1'b0));
    add_row(reg_row(REG_SLOT_TIME, 20'd512000));
    add_row(slot_row(1'b0, 1'b0));
    add_row(slot_row(1'b1, 1'b1));
    add_row(reg_row(REG_SLOT_TIME, 20'hFFFFF));
    add_row(reg_row(REG_GUARD_TIME, 20'd0));
    add_row(reg_row(REG_FRAME_TIME, 20'hFFFFF));
    add_row(slot_row(1'b1, 1'b1));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    dirty = 1'b0;
    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_REG) begin
        if (dirty) quiesce();
        dirty = 1'b0;
        write_reg(row.idx, row.data);
      end else begin
        send(row.reserved, row.last, row.typed, row.cap);
        dirty = 1'b1;
      end
    end

    phase = 0;
    while (beats_sent < 760) begin
      quiesce();
      if ($urandom_range(0, 1)) write_reg(REG_SLOT_TIME, pick_time(1));
      if ($urandom_range(0, 1)) write_reg(REG_GUARD_TIME, pick_time(0));
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_TIME, pick_time(1));
      if ($urandom_range(0, 1)) write_reg(REG_TARGET, pick_target());
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 4) begin
        hold_req = 1'b1;
        repeat (20) send(1'($urandom), 1'b1, 1'b0, '0);
      end
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0:       density = 20;
          1:       density = 50;
          2:       density = 85;
          default: density = 100;
        endcase
        len = $urandom_range(0, 99);
        if (len < 3) begin
          len = $urandom_range(257, 300);
          density = 100;
        end else if (len < 10) begin
          len = $urandom_range(41, 256);
        end else begin
          len = $urandom_range(2, 24);
        end
        send_map(len, density);
      end
      // leave a map open across the next register writes
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 8)) send(1'($urandom), 1'b0, 1'b0, '0);
      phase++;
    end
    calm = 1'b0;

    quiesce();
    if (fails == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
